// ===== hdl/sgcb_pkg.sv =====
// shared command codes, port codes and frame type for the serial gpio command bridge
package sgcb_pkg;

    localparam int BYTE_W    = 8;
    localparam int NUM_PORTS = 3;
    localparam int FRAME_MAX = 3;
    localparam int COUNT_W   = 2;

    localparam logic [BYTE_W-1:0] CMD_SET_DIR = 8'h81;
    localparam logic [BYTE_W-1:0] CMD_CLR_DIR = 8'h83;
    localparam logic [BYTE_W-1:0] CMD_GET_DIR = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_SET_OUT = 8'h41;
    localparam logic [BYTE_W-1:0] CMD_CLR_OUT = 8'h43;
    localparam logic [BYTE_W-1:0] CMD_GET_OUT = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_TOGGLE  = 8'h20;
    localparam logic [BYTE_W-1:0] ERR_MARK    = 8'hFF;

    localparam logic [BYTE_W-1:0] PORT_CODE_B = 8'h01;
    localparam logic [BYTE_W-1:0] PORT_CODE_C = 8'h02;
    localparam logic [BYTE_W-1:0] PORT_CODE_D = 8'h04;

    localparam logic [1:0] PORT_B = 2'd0;
    localparam logic [1:0] PORT_C = 2'd1;
    localparam logic [1:0] PORT_D = 2'd2;

    // one response frame plus the register snapshot sent with every byte
    typedef struct packed {
        logic [FRAME_MAX-1:0][BYTE_W-1:0] bytes;
        logic [COUNT_W-1:0]               count;
        logic [NUM_PORTS-1:0][BYTE_W-1:0] dir;
        logic [NUM_PORTS-1:0][BYTE_W-1:0] outs;
    } t_frame;

endpackage

// ===== hdl/sgcb_parser.sv =====
// command parser: phase tracking, port registers and response frame build
module sgcb_parser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [sgcb_pkg::BYTE_W-1:0]  i_rx_byte,
    input  logic [sgcb_pkg::BYTE_W-1:0]  i_pins_b,
    input  logic [sgcb_pkg::BYTE_W-1:0]  i_pins_c,
    input  logic [sgcb_pkg::BYTE_W-1:0]  i_pins_d,
    input  logic                         i_line_error,
    output sgcb_pkg::t_frame             o_frame
);

    localparam logic [1:0] PH_CMD  = 2'd0;
    localparam logic [1:0] PH_PAY1 = 2'd1;
    localparam logic [1:0] PH_PAY2 = 2'd2;

    logic [1:0]                                   r_phase, n_phase;
    logic [sgcb_pkg::BYTE_W-1:0]                  r_held, n_held;
    logic [sgcb_pkg::BYTE_W-1:0]                  r_port, n_port;
    logic [sgcb_pkg::NUM_PORTS-1:0][sgcb_pkg::BYTE_W-1:0] r_dir, n_dir;
    logic [sgcb_pkg::NUM_PORTS-1:0][sgcb_pkg::BYTE_W-1:0] r_out, n_out;
    logic [sgcb_pkg::NUM_PORTS-1:0][sgcb_pkg::BYTE_W-1:0] pins;

    logic                        rx_port_ok, held_port_ok, known_cmd, held_get;
    logic [1:0]                  rx_idx, held_idx;
    logic [sgcb_pkg::BYTE_W-1:0] err_cmd;
    logic                        err;

    assign pins = {i_pins_d, i_pins_c, i_pins_b};

    always_comb begin
        rx_port_ok = 1'b1;
        rx_idx     = sgcb_pkg::PORT_B;
        unique case (i_rx_byte)
            sgcb_pkg::PORT_CODE_B: rx_idx = sgcb_pkg::PORT_B;
            sgcb_pkg::PORT_CODE_C: rx_idx = sgcb_pkg::PORT_C;
            sgcb_pkg::PORT_CODE_D: rx_idx = sgcb_pkg::PORT_D;
            default:               rx_port_ok = 1'b0;
        endcase
        held_port_ok = 1'b1;
        held_idx     = sgcb_pkg::PORT_B;
        unique case (r_port)
            sgcb_pkg::PORT_CODE_B: held_idx = sgcb_pkg::PORT_B;
            sgcb_pkg::PORT_CODE_C: held_idx = sgcb_pkg::PORT_C;
            sgcb_pkg::PORT_CODE_D: held_idx = sgcb_pkg::PORT_D;
            default:               held_port_ok = 1'b0;
        endcase
    end

    always_comb begin
        unique case (i_rx_byte) inside
            sgcb_pkg::CMD_SET_DIR, sgcb_pkg::CMD_CLR_DIR, sgcb_pkg::CMD_GET_DIR,
            sgcb_pkg::CMD_SET_OUT, sgcb_pkg::CMD_CLR_OUT, sgcb_pkg::CMD_GET_OUT,
            sgcb_pkg::CMD_TOGGLE: known_cmd = 1'b1;
            default:              known_cmd = 1'b0;
        endcase
    end

    assign held_get = (r_held == sgcb_pkg::CMD_GET_DIR) || (r_held == sgcb_pkg::CMD_GET_OUT);

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_port  = r_port;
        n_dir   = r_dir;
        n_out   = r_out;
        err     = 1'b0;
        err_cmd = r_held;
        o_frame.bytes = '0;
        o_frame.count = '0;
        unique case (r_phase)
            PH_PAY1: begin
                if (held_get) begin
                    n_phase = PH_CMD;
                    if (!rx_port_ok) begin
                        err = 1'b1;
                    end else begin
                        o_frame.bytes[0] = r_held;
                        o_frame.bytes[1] = (r_held == sgcb_pkg::CMD_GET_DIR) ?
                                           r_dir[rx_idx] : pins[rx_idx];
                        o_frame.count    = 2'd2;
                    end
                end else begin
                    n_port  = i_rx_byte;
                    n_phase = PH_PAY2;
                end
            end
            PH_PAY2: begin
                n_phase = PH_CMD;
                if (!held_port_ok) begin
                    err = 1'b1;
                end else begin
                    o_frame.bytes[0] = r_held;
                    o_frame.count    = 2'd1;
                    unique case (r_held)
                        sgcb_pkg::CMD_SET_DIR: n_dir[held_idx] = r_dir[held_idx] | i_rx_byte;
                        sgcb_pkg::CMD_CLR_DIR: n_dir[held_idx] = r_dir[held_idx] & ~i_rx_byte;
                        sgcb_pkg::CMD_SET_OUT: n_out[held_idx] = r_out[held_idx] | i_rx_byte;
                        sgcb_pkg::CMD_CLR_OUT: n_out[held_idx] = r_out[held_idx] & ~i_rx_byte;
                        sgcb_pkg::CMD_TOGGLE:  n_out[held_idx] = r_out[held_idx] ^ i_rx_byte;
                        default: begin
                            err           = 1'b1;
                            o_frame.count = '0;
                        end
                    endcase
                end
            end
            default: begin
                // awaiting command, the unused phase code lands here too
                n_held  = i_rx_byte;
                err_cmd = i_rx_byte;
                if (known_cmd) begin
                    n_phase = PH_PAY1;
                end else begin
                    err     = 1'b1;
                    n_phase = PH_CMD;
                end
            end
        endcase
        if (err) begin
            o_frame.bytes[0] = sgcb_pkg::ERR_MARK;
            o_frame.bytes[1] = err_cmd;
            o_frame.bytes[2] = {{(sgcb_pkg::BYTE_W-1){1'b0}}, i_line_error};
            o_frame.count    = 2'd3;
        end
        o_frame.dir  = n_dir;
        o_frame.outs = n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_held  <= '0;
            r_port  <= '0;
            r_dir   <= '0;
            r_out   <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_port  <= n_port;
            r_dir   <= n_dir;
            r_out   <= n_out;
        end
    end

endmodule

// ===== hdl/serial_gpio_command_bridge.sv =====
// top level of the serial gpio command bridge: parser plus response frame buffer
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  in       | i_in_valid / o_in_ready   | i_rx_byte, i_pins_b/c/d, i_line_error
//  out      | o_out_valid / i_out_ready | o_tx_byte, o_frame_end, o_dir_b/c/d, o_out_b/c/d
//
// each received byte is parsed in the cycle it is accepted and its frame (0 to 3 bytes)
// lands in the frame buffer at that edge; the buffer sends one byte per cycle while
// i_out_ready is high. a byte is accepted while the buffer is empty or its last byte
// leaves in that cycle, so a new byte can enter as the last frame byte is taken.
// reset (i_rst_n low, synchronous) clears phase, command, port and gpio registers
// and empties the buffer; a stalled output holds the frame byte and its snapshot.
module serial_gpio_command_bridge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [sgcb_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic [sgcb_pkg::BYTE_W-1:0] i_pins_b,
    input  logic [sgcb_pkg::BYTE_W-1:0] i_pins_c,
    input  logic [sgcb_pkg::BYTE_W-1:0] i_pins_d,
    input  logic                        i_line_error,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [sgcb_pkg::BYTE_W-1:0] o_tx_byte,
    output logic                        o_frame_end,
    output logic [sgcb_pkg::BYTE_W-1:0] o_dir_b,
    output logic [sgcb_pkg::BYTE_W-1:0] o_dir_c,
    output logic [sgcb_pkg::BYTE_W-1:0] o_dir_d,
    output logic [sgcb_pkg::BYTE_W-1:0] o_out_b,
    output logic [sgcb_pkg::BYTE_W-1:0] o_out_c,
    output logic [sgcb_pkg::BYTE_W-1:0] o_out_d
);

    sgcb_pkg::t_frame frame;

    logic [sgcb_pkg::FRAME_MAX-1:0][sgcb_pkg::BYTE_W-1:0] r_bytes;
    logic [sgcb_pkg::COUNT_W-1:0]                         r_count;
    logic [sgcb_pkg::NUM_PORTS-1:0][sgcb_pkg::BYTE_W-1:0] r_dir;
    logic [sgcb_pkg::NUM_PORTS-1:0][sgcb_pkg::BYTE_W-1:0] r_outs;

    logic in_fire, out_fire;

    assign o_out_valid = (r_count != '0);
    assign out_fire    = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_count == '0) || (out_fire && r_count == 2'd1);
    assign in_fire     = i_in_valid && o_in_ready;

    sgcb_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (in_fire),
        .i_rx_byte    (i_rx_byte),
        .i_pins_b     (i_pins_b),
        .i_pins_c     (i_pins_c),
        .i_pins_d     (i_pins_d),
        .i_line_error (i_line_error),
        .o_frame      (frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_fire && frame.count != '0) begin
            r_count <= frame.count;
        end else if (out_fire) begin
            r_count <= r_count - 2'd1;
        end
    end

    // payload: load a fresh frame or shift the next byte to the front
    always_ff @(posedge i_clk) begin
        if (in_fire && frame.count != '0) begin
            r_bytes <= frame.bytes;
            r_dir   <= frame.dir;
            r_outs  <= frame.outs;
        end else if (out_fire) begin
            r_bytes <= {{sgcb_pkg::BYTE_W{1'b0}}, r_bytes[sgcb_pkg::FRAME_MAX-1:1]};
        end
    end

    assign o_tx_byte   = r_bytes[0];
    assign o_frame_end = (r_count == 2'd1);
    assign o_dir_b     = r_dir[sgcb_pkg::PORT_B];
    assign o_dir_c     = r_dir[sgcb_pkg::PORT_C];
    assign o_dir_d     = r_dir[sgcb_pkg::PORT_D];
    assign o_out_b     = r_outs[sgcb_pkg::PORT_B];
    assign o_out_c     = r_outs[sgcb_pkg::PORT_C];
    assign o_out_d     = r_outs[sgcb_pkg::PORT_D];

    // last byte taken with nothing new coming in leaves the buffer empty
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_frame_end && !in_fire) |=> !o_out_valid)
        else $error("frame buffer not empty after last byte");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty frame buffer");

    // no new transaction while a frame still has bytes after the current one
    a_mid_frame_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_end) |-> !o_in_ready)
        else $error("input accepted in the middle of a frame");

    a_error_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && frame.count == 2'd3) |=>
            (o_tx_byte == sgcb_pkg::ERR_MARK && r_count == 2'd3))
        else $error("error frame not loaded with its mark");

endmodule
